### hdl/tt_pkg.sv
`default_nettype none
package tt_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_NLOAD,
		ST_NSHIFT,
		ST_NSQ,
		ST_SQRT,
		ST_DLOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	// largest positive unit-vector code
	localparam logic [15:0] Q_MAX = 16'd32767;

	// number of products per triangle: two for the determinant plus four per axis
	localparam int N_PROD = 14;

endpackage
`default_nettype wire

### hdl/triangle_tangent_basis.sv
`default_nettype none
// Per-triangle tangent and bitangent from texture coordinates.
// Input channel (in_valid/in_stall) takes one vertex per transfer: position
// and uv in signed fixed point, plus mesh_start which restarts grouping.
// The first two vertices of a triangle are held; in_stall stays low for them.
// The third starts the computation; in_stall stays high until all three
// result copies have been transferred on the output channel
// (out_valid/out_stall). The copies are identical except last_of_triangle,
// which marks the third one.
// Work per triangle: 14 products on one shift-add multiplier
// (MW = max(COORD_WIDTH+1, 32)), then per vector a right-shift normalization,
// 3 squares on the same multiplier, 32 square-root steps and three 64-step
// divisions; a zero determinant or a zero-length vector skips the later steps.
// A stalled output holds its copy; nothing else advances while stalled.
// Reset clears the vertex slot and the sequencer; held vertices are
// undefined until written.
module triangle_tangent_basis #(
	parameter int COORD_WIDTH   = 32,
	parameter int OUT_FRAC_BITS = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_WIDTH-1:0] pos_x,
	input  wire logic signed [COORD_WIDTH-1:0] pos_y,
	input  wire logic signed [COORD_WIDTH-1:0] pos_z,
	input  wire logic signed [COORD_WIDTH-1:0] tex_u,
	input  wire logic signed [COORD_WIDTH-1:0] tex_v,
	input  wire logic                          mesh_start,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [15:0]                 tangent_x,
	output logic signed [15:0]                 tangent_y,
	output logic signed [15:0]                 tangent_z,
	output logic signed [15:0]                 bitangent_x,
	output logic signed [15:0]                 bitangent_y,
	output logic signed [15:0]                 bitangent_z,
	output logic                               degenerate,
	output logic                               last_of_triangle
);
	localparam int W   = COORD_WIDTH;
	localparam int DW  = W + 1;
	localparam int MW  = (W + 1 > 32) ? W + 1 : 32;
	localparam int PW  = 2 * MW;
	localparam int VW  = PW + 1;

	tt_pkg::state_t state_q, state_n;

	logic [1:0]          slot_q, slot_eff;
	logic signed [W-1:0] hp_q [6];
	logic signed [W-1:0] ht_q [4];
	logic signed [DW-1:0] d1_q [3];
	logic signed [DW-1:0] d2_q [3];
	logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [W-1:0] pin [3];

	logic [3:0]            pidx_q;
	logic signed [PW-1:0]  first_q;
	logic signed [VW-1:0]  det_q;
	logic signed [VW-1:0]  vec_q [6];
	logic                  vi_q;
	logic [VW-1:0]         m_q [3];
	logic                  neg_q [3];
	logic [1:0]            k_q;
	logic [63:0]           sum_q, sum_n;
	logic [63:0]           sx_q, sr_q, sb_q;
	logic [31:0]           len_q;
	logic [63:0]           num_q, quo_q;
	logic [32:0]           rem_q, rem_n;
	logic [5:0]            dcnt_q;
	logic [15:0]           res_q [6];
	logic                  degen_q;
	logic [1:0]            copy_q;
	logic                  issue_q;

	logic                  in_acc, out_acc;
	logic signed [MW-1:0]  op_a, op_b;
	logic                  mul_done;
	logic signed [PW-1:0]  mul_p;
	logic [3:0]            pj;
	logic [1:0]            pk;
	logic [VW-1:0]         m_or;
	logic [63:0]           sq_t;
	logic [63:0]           quo_n;
	logic [15:0]           q16;
	logic signed [VW-1:0]  vsel [3];

	assign pin[0] = pos_x;
	assign pin[1] = pos_y;
	assign pin[2] = pos_z;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign slot_eff = (mesh_start || slot_q == 2'd3) ? 2'd0 : slot_q;

	// product operand select
	assign pj = pidx_q - 4'd2;
	assign pk = pj[3:2];
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == tt_pkg::ST_NSQ) begin
			op_a = MW'(m_q[k_q][30:0]);
			op_b = MW'(m_q[k_q][30:0]);
			op_a[MW-1] = 1'b0;
			op_b[MW-1] = 1'b0;
		end else if (pidx_q == 4'd0) begin
			op_a = MW'(du1_q);
			op_b = MW'(dv2_q);
		end else if (pidx_q == 4'd1) begin
			op_a = MW'(dv1_q);
			op_b = MW'(du2_q);
		end else begin
			case (pj[1:0])
				2'd0:    begin op_a = MW'(d1_q[pk]); op_b = MW'(dv2_q); end
				2'd1:    begin op_a = MW'(d2_q[pk]); op_b = MW'(dv1_q); end
				2'd2:    begin op_a = MW'(d2_q[pk]); op_b = MW'(du1_q); end
				default: begin op_a = MW'(d1_q[pk]); op_b = MW'(du2_q); end
			endcase
		end
	end

	tt_mul #(.MW(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (issue_q),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// normalize helpers
	assign m_or  = m_q[0] | m_q[1] | m_q[2];
	assign sum_n = sum_q + 64'(unsigned'(mul_p));
	assign sq_t  = sr_q + sb_q;
	assign rem_n = {rem_q[31:0], num_q[63]};
	assign quo_n = {quo_q[62:0], (rem_n >= {1'b0, len_q})};
	assign q16   = (quo_n > 64'(tt_pkg::Q_MAX)) ? tt_pkg::Q_MAX : quo_n[15:0];
	always_comb begin
		for (int i = 0; i < 3; i++)
			vsel[i] = vi_q ? vec_q[3+i] : vec_q[i];
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			tt_pkg::ST_IDLE:
				if (in_acc && slot_eff == 2'd2)
					state_n = tt_pkg::ST_MUL;
			tt_pkg::ST_MUL:
				if (mul_done && pidx_q == 4'(tt_pkg::N_PROD - 1))
					state_n = (det_q == '0) ? tt_pkg::ST_EMIT : tt_pkg::ST_NLOAD;
			tt_pkg::ST_NLOAD:
				state_n = tt_pkg::ST_NSHIFT;
			tt_pkg::ST_NSHIFT:
				if (m_or[VW-1:31] == '0)
					state_n = tt_pkg::ST_NSQ;
			tt_pkg::ST_NSQ:
				if (mul_done && k_q == 2'd2) begin
					if (sum_n != '0)
						state_n = tt_pkg::ST_SQRT;
					else if (!vi_q)
						state_n = tt_pkg::ST_NLOAD;
					else
						state_n = tt_pkg::ST_EMIT;
				end
			tt_pkg::ST_SQRT:
				if (sb_q[0])
					state_n = tt_pkg::ST_DLOAD;
			tt_pkg::ST_DLOAD:
				state_n = tt_pkg::ST_DIV;
			tt_pkg::ST_DIV:
				if (dcnt_q == '0) begin
					if (k_q != 2'd2)
						state_n = tt_pkg::ST_DLOAD;
					else if (!vi_q)
						state_n = tt_pkg::ST_NLOAD;
					else
						state_n = tt_pkg::ST_EMIT;
				end
			tt_pkg::ST_EMIT:
				if (out_acc && copy_q == 2'd2)
					state_n = tt_pkg::ST_IDLE;
			default:
				state_n = tt_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall  = (state_q != tt_pkg::ST_IDLE);
		out_valid = (state_q == tt_pkg::ST_EMIT);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tt_pkg::ST_IDLE;
			slot_q  <= 2'd0;
			issue_q <= 1'b0;
			copy_q  <= 2'd0;
		end else begin
			state_q <= state_n;
			issue_q <= 1'b0;
			if (in_acc)
				slot_q <= (slot_eff == 2'd2) ? 2'd0 : slot_eff + 2'd1;
			if (in_acc && slot_eff == 2'd2)
				issue_q <= 1'b1;
			if (state_q == tt_pkg::ST_MUL && mul_done &&
				pidx_q != 4'(tt_pkg::N_PROD - 1))
				issue_q <= 1'b1;
			if (state_q == tt_pkg::ST_NSHIFT && m_or[VW-1:31] == '0)
				issue_q <= 1'b1;
			if (state_q == tt_pkg::ST_NSQ && mul_done && k_q != 2'd2)
				issue_q <= 1'b1;
			if (out_acc)
				copy_q <= (copy_q == 2'd2) ? 2'd0 : copy_q + 2'd1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			tt_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (slot_eff != 2'd2) begin
						for (int i = 0; i < 3; i++)
							hp_q[3*slot_eff+i] <= pin[i];
						ht_q[2*slot_eff]   <= tex_u;
						ht_q[2*slot_eff+1] <= tex_v;
					end else begin
						for (int i = 0; i < 3; i++) begin
							d1_q[i] <= DW'(hp_q[3+i]) - DW'(hp_q[i]);
							d2_q[i] <= DW'(pin[i]) - DW'(hp_q[i]);
						end
						du1_q  <= DW'(ht_q[2]) - DW'(ht_q[0]);
						dv1_q  <= DW'(ht_q[3]) - DW'(ht_q[1]);
						du2_q  <= DW'(tex_u) - DW'(ht_q[0]);
						dv2_q  <= DW'(tex_v) - DW'(ht_q[1]);
						pidx_q <= 4'd0;
						vi_q   <= 1'b0;
						degen_q <= 1'b0;
						for (int i = 0; i < 6; i++)
							res_q[i] <= '0;
					end
				end
			end
			tt_pkg::ST_MUL: begin
				if (mul_done) begin
					pidx_q <= pidx_q + 4'd1;
					if (!pidx_q[0])
						first_q <= mul_p;
					else if (pidx_q == 4'd1)
						det_q <= VW'(first_q) - VW'(mul_p);
					else
						vec_q[{1'b0, pk} + (pj[1] ? 3'd3 : 3'd0)] <=
							VW'(first_q) - VW'(mul_p);
					if (pidx_q == 4'(tt_pkg::N_PROD - 1) && det_q == '0)
						degen_q <= 1'b1;
				end
			end
			tt_pkg::ST_NLOAD: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= vsel[i][VW-1] ? -vsel[i] : vsel[i];
					neg_q[i] <= vsel[i][VW-1] ^ det_q[VW-1];
				end
				k_q   <= 2'd0;
				sum_q <= '0;
			end
			tt_pkg::ST_NSHIFT: begin
				if (m_or[VW-1:31] != '0)
					for (int i = 0; i < 3; i++)
						m_q[i] <= m_q[i] >> 1;
			end
			tt_pkg::ST_NSQ: begin
				if (mul_done) begin
					sum_q <= sum_n;
					k_q   <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						sx_q <= sum_n;
						sr_q <= '0;
						sb_q <= 64'd1 << 62;
						k_q  <= 2'd0;
						if (sum_n == '0) begin
							degen_q <= 1'b1;
							vi_q    <= 1'b1;
						end
					end
				end
			end
			tt_pkg::ST_SQRT: begin
				if (sx_q >= sq_t) begin
					sx_q <= sx_q - sq_t;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
				if (sb_q[0])
					len_q <= (sx_q >= sq_t) ? 32'((sr_q >> 1) + sb_q) : 32'(sr_q >> 1);
			end
			tt_pkg::ST_DLOAD: begin
				num_q  <= (64'(m_q[k_q][30:0]) << OUT_FRAC_BITS) + 64'(len_q >> 1);
				rem_q  <= '0;
				quo_q  <= '0;
				dcnt_q <= 6'd63;
			end
			tt_pkg::ST_DIV: begin
				rem_q  <= (rem_n >= {1'b0, len_q}) ? rem_n - {1'b0, len_q} : rem_n;
				num_q  <= num_q << 1;
				quo_q  <= quo_n;
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == '0) begin
					res_q[(vi_q ? 3'd3 : 3'd0) + {1'b0, k_q}] <=
						neg_q[k_q] ? -q16 : q16;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2)
						vi_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result fields
	assign tangent_x        = res_q[0];
	assign tangent_y        = res_q[1];
	assign tangent_z        = res_q[2];
	assign bitangent_x      = res_q[3];
	assign bitangent_y      = res_q[4];
	assign bitangent_z      = res_q[5];
	assign degenerate       = degen_q;
	assign last_of_triangle = (copy_q == 2'd2);
endmodule
`default_nettype wire

### hdl/tt_mul.sv
`default_nettype none
// Shift-add signed multiplier, one operand bit per cycle.
module tt_mul #(
	parameter int MW = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [MW-1:0] a,
	input  wire logic signed [MW-1:0] b,
	output logic                      done,
	output logic signed [2*MW-1:0]    p
);
	localparam int CW = $clog2(MW + 1);

	logic [2*MW-1:0] ma_q, acc_q;
	logic [MW-1:0]   mb_q, ua, ub;
	logic            neg_q, busy_q, done_q;
	logic [CW-1:0]   cnt_q;

	// operand magnitudes
	assign ua = a[MW-1] ? (~a + 1'b1) : a;
	assign ub = b[MW-1] ? (~b + 1'b1) : b;

	// iterate over multiplier bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ma_q   <= {{MW{1'b0}}, ua};
				mb_q   <= ub;
				acc_q  <= '0;
				neg_q  <= a[MW-1] ^ b[MW-1];
				cnt_q  <= CW'(MW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (mb_q[0])
					acc_q <= acc_q + ma_q;
				ma_q  <= ma_q << 1;
				mb_q  <= mb_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p    = neg_q ? -$signed(acc_q) : $signed(acc_q);
endmodule
`default_nettype wire

### test/tb_triangle_tangent_basis.sv
`default_nettype none
module tb_triangle_tangent_basis;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 32;
	localparam int FRAC = 14;
	localparam logic signed [15:0] ONE = 16'sd16384;
	localparam logic signed [31:0] CMAX = 32'sh7fffffff;
	localparam logic signed [31:0] CMIN = 32'sh80000000;
	localparam int N_ITEMS = 470;
	localparam int QUIET_AFTER = 420;

	typedef struct packed {
		logic signed [15:0] tx, ty, tz, bx, by, bz;
		logic               degen, last;
	} basis_t;

	typedef struct packed {
		logic signed [CW-1:0] x, y, z, u, v;
		logic                 ms;
		logic                 typed;
		basis_t               want;
	} vertex_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
	logic                 mesh_start = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [15:0]   tangent_x, tangent_y, tangent_z;
	logic signed [15:0]   bitangent_x, bitangent_y, bitangent_z;
	logic                 degenerate, last_of_triangle;

	triangle_tangent_basis #(.COORD_WIDTH(CW), .OUT_FRAC_BITS(FRAC)) dut (.*);

	always #5 clk = ~clk;

	// predictor state: slot within triangle, held vertices
	logic [1:0] slot;
	longint     held_pos[6];
	longint     held_uv[4];

	basis_t  basis_q[$];
	vertex_t dir_rows[$];
	int      mismatches = 0;
	int      sent = 0;
	bit      quiet = 0;
	int      stall_hold = 0;
	basis_t  got, want;

	function automatic logic signed [127:0] wmul(input longint a, input longint b);
		logic signed [127:0] wa, wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// scale a vector to unit length in Q1.14; returns 1 on zero length
	function automatic bit unit_vec(input logic signed [127:0] c0, c1, c2, input bit flip,
			output logic signed [15:0] r0, r1, r2);
		logic signed [127:0] c[3];
		logic [127:0]        m[3];
		logic [127:0]        orv;
		bit                  neg[3];
		longint unsigned     sm[3], sum, len, q;
		logic [15:0]         r[3];
		int                  sh;
		c[0] = c0; c[1] = c1; c[2] = c2;
		orv = '0;
		for (int k = 0; k < 3; k++) begin
			neg[k] = (c[k] < 0) ^ flip;
			m[k] = (c[k] < 0) ? -c[k] : c[k];
			orv |= m[k];
		end
		sh = 0;
		while ((orv >> 31) != 0) begin
			orv >>= 1;
			sh++;
		end
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			sm[k] = 64'(m[k] >> sh);
			sum += sm[k] * sm[k];
		end
		if (sum == 0) begin
			r0 = 0; r1 = 0; r2 = 0;
			return 1;
		end
		len = int_sqrt(sum);
		for (int k = 0; k < 3; k++) begin
			q = ((sm[k] << FRAC) + len / 2) / len;
			if (q > 32767) q = 32767;
			r[k] = neg[k] ? 16'(-q) : 16'(q);
		end
		r0 = r[0]; r1 = r[1]; r2 = r[2];
		return 0;
	endfunction

	// advance the vertex grouping; on a completed triangle return its basis
	function automatic bit triangle_basis(input vertex_t vin, output basis_t res);
		longint              p[3], u, v, du1, dv1, du2, dv2, d1, d2;
		logic signed [127:0] det, tv[3], bv[3];
		bit                  flip, zt, zb;
		p[0] = vin.x; p[1] = vin.y; p[2] = vin.z;
		u = vin.u;
		v = vin.v;
		res = '0;
		if (vin.ms) slot = 0;
		if (slot > 2) slot = 0;
		if (slot < 2) begin
			for (int k = 0; k < 3; k++) held_pos[slot * 3 + k] = p[k];
			held_uv[slot * 2] = u;
			held_uv[slot * 2 + 1] = v;
			slot++;
			return 0;
		end
		slot = 0;
		du1 = held_uv[2] - held_uv[0];
		dv1 = held_uv[3] - held_uv[1];
		du2 = u - held_uv[0];
		dv2 = v - held_uv[1];
		det = wmul(du1, dv2) - wmul(dv1, du2);
		if (det == 0) begin
			res.degen = 1;
			return 1;
		end
		flip = det < 0;
		for (int k = 0; k < 3; k++) begin
			d1 = held_pos[3 + k] - held_pos[k];
			d2 = p[k] - held_pos[k];
			tv[k] = wmul(d1, dv2) - wmul(d2, dv1);
			bv[k] = wmul(d2, du1) - wmul(d1, du2);
		end
		zt = unit_vec(tv[0], tv[1], tv[2], flip, res.tx, res.ty, res.tz);
		zb = unit_vec(bv[0], bv[1], bv[2], flip, res.bx, res.by, res.bz);
		res.degen = zt | zb;
		return 1;
	endfunction

	// one vertex transfer, with an optional gap before it
	task automatic send_vertex(input vertex_t vin);
		basis_t res;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= vin.x; pos_y <= vin.y; pos_z <= vin.z;
		tex_u <= vin.u; tex_v <= vin.v;
		mesh_start <= vin.ms;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (triangle_basis(vin, res)) begin
			if (vin.typed) res = vin.want;
			for (int r = 0; r < 3; r++) begin
				res.last = (r == 2);
				basis_q.insert(basis_q.size(), res);
			end
		end
	endtask

	task automatic add_row(input logic signed [CW-1:0] x, y, z, u, v, input logic ms);
		vertex_t t;
		t = '0;
		t.x = x; t.y = y; t.z = z; t.u = u; t.v = v; t.ms = ms;
		dir_rows.insert(dir_rows.size(), t);
	endtask

	// typed expectation on the last row added
	task automatic want_last(input logic signed [15:0] tx, ty, tz, bx, by, bz, input logic dg);
		vertex_t t;
		t = dir_rows.pop_back();
		t.typed = 1;
		t.want = '{tx, ty, tz, bx, by, bz, dg, 1'b0};
		dir_rows.insert(dir_rows.size(), t);
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $urandom_range(0, 1 << 20) - (1 << 19);
			3: return $urandom_range(0, 255) << 16;
			4: begin
				case ($urandom_range(0, 3))
					0: return CMAX;
					1: return CMIN;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return -$signed($urandom_range(0, 1 << 24));
		endcase
	endfunction

	function automatic vertex_t rand_vertex(input logic ms);
		vertex_t t;
		t = '0;
		t.x = rand_coord(); t.y = rand_coord(); t.z = rand_coord();
		t.u = rand_coord(); t.v = rand_coord();
		t.ms = ms;
		return t;
	endfunction

	// input: directed rows, then random triangles
	initial begin
		vertex_t tvx[3];
		int      n;
		slot = 0;
		for (int k = 0; k < 6; k++) held_pos[k] = 0;
		for (int k = 0; k < 4; k++) held_uv[k] = 0;

		// unit square mapping: tangent along x, bitangent along y
		add_row(0, 0, 0, 0, 0, 1);
		add_row(32'sh10000, 0, 0, 32'sh10000, 0, 0);
		add_row(0, 32'sh10000, 0, 0, 32'sh10000, 0);
		want_last(ONE, 0, 0, 0, ONE, 0, 0);
		// mirrored uv: negative determinant
		add_row(0, 0, 0, 0, 0, 0);
		add_row(32'sh10000, 0, 0, 0, 32'sh10000, 0);
		add_row(0, 32'sh10000, 0, 32'sh10000, 0, 0);
		// zero determinant: all uv equal
		add_row(5, 6, 7, 32'sh1234, -3, 0);
		add_row(-9, 100, 3, 32'sh1234, -3, 0);
		add_row(77, -8, 1, 32'sh1234, -3, 0);
		want_last(0, 0, 0, 0, 0, 0, 1);
		// zero-length tangent only
		add_row(0, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 32'sh10000, 0, 0);
		add_row(32'sh10000, 0, 0, 0, 32'sh10000, 0);
		want_last(0, 0, 0, ONE, 0, 0, 1);
		// mesh start in mid triangle discards the partial one
		add_row(CMAX, CMAX, CMAX, CMAX, CMIN, 0);
		add_row(CMIN, CMIN, CMIN, CMIN, CMAX, 1);
		add_row(CMAX, -1, CMIN, 0, CMAX, 0);
		add_row(-1, CMAX, 0, CMIN, -1, 0);
		// extremes everywhere
		add_row(CMIN, CMAX, -1, CMIN, CMIN, 1);
		add_row(CMAX, CMIN, CMAX, CMAX, CMIN, 0);
		add_row(CMIN, CMIN, CMIN, CMIN, CMAX, 0);
		// equal positions: both vectors zero length
		add_row(-1, -1, -1, 0, 0, 0);
		add_row(-1, -1, -1, 32'sh10000, 0, 0);
		add_row(-1, -1, -1, 0, 32'sh10000, 0);
		want_last(0, 0, 0, 0, 0, 0, 1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) send_vertex(dir_rows[i]);

		while (sent < N_ITEMS) begin
			if (sent >= QUIET_AFTER) quiet = 1;
			// let everything drain mid run
			if (sent >= 200 && sent < 203) begin
				in_valid <= 1'b0;
				while (basis_q.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			tvx[0] = rand_vertex($urandom_range(0, 3) == 0);
			tvx[1] = rand_vertex(0);
			tvx[2] = rand_vertex(0);
			if ($urandom_range(0, 9) == 0) begin
				tvx[2].u = tvx[0].u;
				tvx[2].v = tvx[0].v;
				tvx[1].u = tvx[0].u;
			end
			if ($urandom_range(0, 9) == 0) begin
				tvx[1].x = tvx[0].x; tvx[1].y = tvx[0].y; tvx[1].z = tvx[0].z;
				tvx[2].x = tvx[0].x; tvx[2].y = tvx[0].y; tvx[2].z = tvx[0].z;
			end
			// broken triangle: cut short, the next one restarts the grouping
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 3;
			for (int k = 0; k < n; k++) send_vertex(tvx[k]);
			if (n < 3) begin
				tvx[0] = rand_vertex(1);
				send_vertex(tvx[0]);
			end
		end
		in_valid <= 1'b0;
		while (basis_q.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (basis_q.size() != 0) mismatches++;
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_hold = $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each output transfer with the oldest expected basis
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got = '{tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
				bitangent_z, degenerate, last_of_triangle};
			if (basis_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output transfer at %0t", $time);
			end else begin
				want = basis_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t: exp t=(%0d %0d %0d) b=(%0d %0d %0d) dg=%0b last=%0b",
							$time, want.tx, want.ty, want.tz, want.bx, want.by, want.bz,
							want.degen, want.last);
						$display("    got t=(%0d %0d %0d) b=(%0d %0d %0d) dg=%0b last=%0b",
							got.tx, got.ty, got.tz, got.bx, got.by, got.bz,
							got.degen, got.last);
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
hdl/tt_pkg.sv
hdl/tt_mul.sv
hdl/triangle_tangent_basis.sv
test/tb_triangle_tangent_basis.sv
